// ===== src/assert_macros.svh =====
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define SAL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sal assertion failed");

// same, with a caller-supplied message
`define SAL_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

// ===== src/sal_pkg.sv =====
// package for the lifo stack allocator: sizes, codes and payload types
package sal_pkg;

  localparam int unsigned HEADER_BYTES = 1;
  localparam int unsigned MAX_LIVE     = 64;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned BYTES_W   = 25;
  localparam int unsigned ALIGN_W   = 3;
  localparam int unsigned PAD_W     = 8;
  localparam int unsigned ACC_W     = ADDR_W + 1;
  localparam int unsigned LIVE_W    = $clog2(MAX_LIVE + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_LIVE);
  localparam int unsigned RAM_W     = PAD_W + ADDR_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = CFG_IDX_W'(1);

  localparam logic [BYTES_W-1:0] POOL_BYTES_RST = BYTES_W'(24'hFFFFFF) + BYTES_W'(1);

  typedef enum logic [0:0] {
    OP_ALLOC,
    OP_FREE
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NO_MEM,
    STAT_BAD_FREE,
    STAT_FULL
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_GRANT,
    ST_SUM1,
    ST_SUM2,
    ST_TOP,
    ST_FCHK,
    ST_FUSED,
    ST_FPAD,
    ST_FTOP,
    ST_DONE
  } sal_state_e;

  typedef struct packed {
    op_e                operation;
    logic [BYTES_W-1:0] request_bytes;
    logic [ALIGN_W-1:0] align_log2;
    logic [ADDR_W-1:0]  free_address;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  block_address;
    status_e            status;
    logic [BYTES_W-1:0] bytes_in_use;
    logic [LIVE_W-1:0]  live_blocks;
  } result_t;

endpackage

// ===== src/stack_allocator_lifo_core.sv =====
// lifo stack allocator with alignment header: sequencer, shared adder and stack ram
//
// A command is taken when start_i is high and busy_o is low; busy_o stays high until the
// result has been shown. Each command gives exactly one result, held on result_o for the
// single cycle in which done_o is high; the receiver cannot stall it, so it must take it
// then. The address and byte sums go through one 33-bit add/subtract unit, one operation
// a cycle: an allocate steps through ST_PAD, ST_GRANT, ST_SUM1, ST_SUM2 and ST_TOP (room
// check), a free through ST_FCHK, ST_FUSED, ST_FPAD and ST_FTOP, a free that does not
// match the top of the stack stops after ST_FCHK, and an allocate on a full stack or a
// free on an empty one goes straight to ST_DONE. The stack of grants and paddings lives
// in a ram read when a free is taken and checked in ST_FCHK. Configuration transfers are
// taken only while the block is idle and start_i is low.
`include "assert_macros.svh"

module stack_allocator_lifo_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  sal_pkg::cmd_t                        command_i,
  output logic                                 done_o,
  output sal_pkg::result_t                     result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sal_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sal_pkg::ADDR_W-1:0]           cfg_data_i
);

  import sal_pkg::*;

  sal_state_e state_q, state_d;

  logic [ADDR_W-1:0]  top_q, top_d;
  logic [BYTES_W-1:0] used_q, used_d;
  logic [LIVE_W-1:0]  live_q, live_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [BYTES_W-1:0] pool_q, pool_d;

  op_e                op_q;
  logic [BYTES_W-1:0] req_q;
  logic [ALIGN_W-1:0] alog_q;
  logic [ADDR_W-1:0]  faddr_q;
  logic [PAD_W-1:0]   pad_q, pad_d;
  logic [ADDR_W-1:0]  grant_q, grant_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  result_t            res_q, res_d;

  logic               accept;
  logic               cfg_we;
  logic               is_full;
  logic               is_empty;

  logic [ACC_W-1:0]   add_a, add_b, add_sum;
  logic               add_sub;

  logic [PAD_W:0]     align_w, mask_w, low_w, pad0_w, need_w, pad_w;

  logic               ram_we, ram_re;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;
  logic [LIVE_W-1:0]  live_m1;
  logic [ADDR_W-1:0]  rd_grant;
  logic [PAD_W-1:0]   rd_pad;

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = (state_q == ST_DONE);
  assign result_o    = res_q;
  assign cfg_ready_o = (state_q == ST_IDLE) && !start_i;
  assign accept      = start_i && !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign is_full     = (live_q >= LIVE_W'(MAX_LIVE));
  assign is_empty    = (live_q == '0);
  assign live_m1     = live_q - LIVE_W'(1);
  assign rd_grant    = ram_rdata[ADDR_W-1:0];
  assign rd_pad      = ram_rdata[ADDR_W +: PAD_W];
  assign ram_wdata   = {pad_q, grant_q};

  // padding to next aligned address, grown to leave room for the header
  always_comb begin
    align_w = (PAD_W+1)'(1) << alog_q;
    mask_w  = align_w - (PAD_W+1)'(1);
    low_w   = (PAD_W+1)'(top_q[PAD_W-1:0]) & mask_w;
    pad0_w  = (align_w - low_w) & mask_w;
    need_w  = (PAD_W+1)'(HEADER_BYTES) - pad0_w;
    pad_w   = pad0_w;
    if (pad0_w < (PAD_W+1)'(HEADER_BYTES)) begin
      pad_w = pad0_w + (((need_w + mask_w) >> alog_q) << alog_q);
    end
  end

  // shared add/subtract unit
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      ST_GRANT: begin
        add_a = ACC_W'(top_q);
        add_b = ACC_W'(pad_q);
      end
      ST_SUM1: begin
        add_a = ACC_W'(used_q);
        add_b = ACC_W'(pad_q);
      end
      ST_SUM2: begin
        add_a = acc_q;
        add_b = ACC_W'(req_q);
      end
      ST_TOP: begin
        add_a = ACC_W'(grant_q);
        add_b = ACC_W'(req_q);
      end
      ST_FCHK: begin
        add_a   = ACC_W'(top_q);
        add_b   = ACC_W'(faddr_q);
        add_sub = 1'b1;
      end
      ST_FUSED: begin
        add_a   = ACC_W'(used_q);
        add_b   = acc_q;
        add_sub = 1'b1;
      end
      ST_FPAD: begin
        add_a   = acc_q;
        add_b   = ACC_W'(pad_q);
        add_sub = 1'b1;
      end
      ST_FTOP: begin
        add_a   = ACC_W'(faddr_q);
        add_b   = ACC_W'(pad_q);
        add_sub = 1'b1;
      end
      default: ;
    endcase
    add_sum = add_sub ? (add_a + ~add_b + ACC_W'(1)) : (add_a + add_b);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i.operation == OP_FREE) begin
            state_d = is_empty ? ST_DONE : ST_FCHK;
          end else begin
            state_d = is_full ? ST_DONE : ST_PAD;
          end
        end
      end
      ST_PAD:   state_d = ST_GRANT;
      ST_GRANT: state_d = ST_SUM1;
      ST_SUM1:  state_d = ST_SUM2;
      ST_SUM2:  state_d = ST_TOP;
      ST_TOP:   state_d = ST_DONE;
      ST_FCHK:  state_d = (rd_grant != faddr_q) ? ST_DONE : ST_FUSED;
      ST_FUSED: state_d = ST_FPAD;
      ST_FPAD:  state_d = ST_FTOP;
      ST_FTOP:  state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    top_d   = top_q;
    used_d  = used_q;
    live_d  = live_q;
    base_d  = base_q;
    pool_d  = pool_q;
    pad_d   = pad_q;
    grant_d = grant_q;
    acc_d   = acc_q;
    res_d   = res_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;

    if (cfg_we) begin
      case (cfg_index_i)
        CFG_POOL_BASE: begin
          base_d = cfg_data_i;
          if (is_empty) begin
            top_d  = cfg_data_i;
            used_d = '0;
          end
        end
        CFG_POOL_BYTES: pool_d = cfg_data_i[BYTES_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.block_address = '0;
          res_d.bytes_in_use  = used_q;
          res_d.live_blocks   = live_q;
          if (command_i.operation == OP_FREE) begin
            ram_re       = 1'b1;
            res_d.status = STAT_BAD_FREE;
          end else begin
            res_d.status = STAT_FULL;
          end
        end
      end
      ST_PAD:   pad_d   = pad_w[PAD_W-1:0];
      ST_GRANT: grant_d = add_sum[ADDR_W-1:0];
      ST_SUM1:  acc_d   = add_sum;
      ST_SUM2:  acc_d   = add_sum;
      ST_TOP: begin
        if (acc_q > ACC_W'(pool_q)) begin
          res_d.status = STAT_NO_MEM;
        end else begin
          top_d               = add_sum[ADDR_W-1:0];
          used_d              = acc_q[BYTES_W-1:0];
          live_d              = live_q + LIVE_W'(1);
          ram_we              = 1'b1;
          res_d.block_address = grant_q;
          res_d.status        = STAT_OK;
          res_d.bytes_in_use  = acc_q[BYTES_W-1:0];
          res_d.live_blocks   = live_q + LIVE_W'(1);
        end
      end
      ST_FCHK: begin
        pad_d = rd_pad;
        acc_d = add_sum;
      end
      ST_FUSED: acc_d = add_sum;
      ST_FPAD:  acc_d = add_sum;
      ST_FTOP: begin
        top_d              = add_sum[ADDR_W-1:0];
        used_d             = acc_q[BYTES_W-1:0];
        live_d             = live_m1;
        res_d.status       = STAT_OK;
        res_d.bytes_in_use = acc_q[BYTES_W-1:0];
        res_d.live_blocks  = live_m1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      top_q   <= '0;
      used_q  <= '0;
      live_q  <= '0;
      base_q  <= '0;
      pool_q  <= POOL_BYTES_RST;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      used_q  <= used_d;
      live_q  <= live_d;
      base_q  <= base_d;
      pool_q  <= pool_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= command_i.operation;
      req_q   <= command_i.request_bytes;
      alog_q  <= command_i.align_log2;
      faddr_q <= command_i.free_address;
    end
    pad_q   <= pad_d;
    grant_q <= grant_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
  end

  sal_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_LIVE)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (live_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (live_m1[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  `SAL_ASSERT(a_live_bounded, clk_i, rst_ni, live_q <= LIVE_W'(MAX_LIVE))
  `SAL_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy_o)
  `SAL_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o && !busy_o)
  `SAL_ASSERT_MSG(a_live_commit, clk_i, rst_ni,
    (live_q != $past(live_q)) |-> ($past(state_q == ST_TOP) || $past(state_q == ST_FTOP)),
    "live count changed outside a commit")
  `SAL_ASSERT_MSG(a_alloc_op, clk_i, rst_ni,
    (state_q == ST_TOP) |-> (op_q == OP_ALLOC),
    "allocate path entered for a free")

endmodule

// ===== src/sal_ram.sv =====
// generic single write port, single read port ram with registered read
module sal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
